// ----- rtl/eutc_pkg.sv -----
// ----------------------------------------------------------------------------
// eutc_pkg
// Shared types, constants and month table for the epoch to UTC calendar
// converter.
// ----------------------------------------------------------------------------
package eutc_pkg;

  // 86400 = 675 * 2^7, so days = ((secs >> 7) * DAY_RECIP) >> 35, exact for
  // every 32-bit secs
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;  // ceil(2^35 / 675)
  localparam logic [9:0]  DAY_DIV_HI    = 10'd675;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [7:0]  FIRST_YEAR_OFS = 8'd70;   // 1970 - 1900
  localparam logic [1:0]  FIRST_YEAR_M4   = 2'd2;   // 1970 mod 4
  localparam logic [6:0]  FIRST_YEAR_M100 = 7'd70;  // 1970 mod 100
  localparam logic [8:0]  FIRST_YEAR_M400 = 9'd370; // 1970 mod 400

  localparam logic [3:0]  LAST_MONTH = 4'd11;
  localparam logic [3:0]  FEBRUARY   = 4'd1;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;     // 1970-01-01 was a Thursday

  typedef struct packed {
    logic load;
    logic day_calc;
    logic tod_calc;
    logic year_step;
    logic month_step;
    logic hms_run;
    logic out_load;
  } eutc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic hms_done;
  } eutc_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      FEBRUARY:                                  len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/eutc_dp.sv -----
// ----------------------------------------------------------------------------
// eutc_dp
// Datapath: reciprocal multiply for the day count, year and month loops,
// time-of-day breakdown and the output register.
// ----------------------------------------------------------------------------
module eutc_dp
  import eutc_pkg::*;
(
  input  logic        clk,
  input  eutc_cmd_t   cmd,
  output eutc_stat_t  stat,
  input  logic [31:0] epoch_seconds,
  output logic        valid_res,
  output logic [7:0]  years_since_1900,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [8:0]  day_of_year,
  output logic [2:0]  weekday,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);

  logic [31:0] secs;
  logic [15:0] days;
  logic [16:0] rem;
  logic [2:0]  mod7;
  logic        is_zero;
  logic [7:0]  year;
  logic [1:0]  y4;
  logic [6:0]  y100;
  logic [8:0]  y400;
  logic [3:0]  mon;
  logic [8:0]  month_start;
  logic [4:0]  hour;
  logic [5:0]  minute;

  logic [24:0] secs_hi;
  logic [50:0] day_prod;
  logic [15:0] day_count;
  logic [25:0] day_base;
  logic [9:0]  hi_rem;
  logic [16:0] tod;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [8:0]  month_end;
  logic [3:0]  wd_sum;
  logic [2:0]  wd;
  logic [8:0]  mday;

  // fold three-bit groups (8 = 1 mod 7) down to one residue
  function automatic logic [2:0] mod7_of(input logic [15:0] v);
    logic [5:0] fold1;
    logic [3:0] fold2;
    logic [2:0] fold3;
    fold1 = {3'd0, v[2:0]} + {3'd0, v[5:3]} + {3'd0, v[8:6]} + {3'd0, v[11:9]}
          + {3'd0, v[14:12]} + {5'd0, v[15]};
    fold2 = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
    fold3 = fold2[2:0] + {2'd0, fold2[3]};
    return (fold3 == 3'd7) ? 3'd0 : fold3;
  endfunction

  assign secs_hi   = secs[31:7];
  assign day_prod  = {26'd0, secs_hi} * {25'd0, DAY_RECIP};
  assign day_count = day_prod[50:35];
  // remainder of the high part, then put back the low seven bits
  assign day_base  = {10'd0, days} * {16'd0, DAY_DIV_HI};
  assign hi_rem    = 10'({1'b0, secs_hi} - day_base);
  assign tod       = {hi_rem, secs[6:0]};

  assign leap      = ((y4 == 2'd0) && (y100 != 7'd0)) || (y400 == 9'd0);
  assign ylen      = leap ? 9'd366 : 9'd365;
  assign mlen      = month_len(mon, leap);
  assign month_end = month_start + 9'(mlen);
  assign wd_sum    = 4'(mod7) + 4'(EPOCH_WEEKDAY);
  assign wd        = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
  assign mday      = days[8:0] - month_start + 9'd1;

  assign stat.year_done  = (days < 16'(ylen));
  assign stat.month_done = (mon == LAST_MONTH) || (month_end > days[8:0]);
  assign stat.hms_done   = (rem < SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs        <= epoch_seconds;
      is_zero     <= (epoch_seconds == 32'd0);
      year        <= FIRST_YEAR_OFS;
      y4          <= FIRST_YEAR_M4;
      y100        <= FIRST_YEAR_M100;
      y400        <= FIRST_YEAR_M400;
      mon         <= '0;
      month_start <= '0;
      hour        <= '0;
      minute      <= '0;
    end else begin
      if (cmd.day_calc) begin
        days <= day_count;
      end
      if (cmd.tod_calc) begin
        rem  <= tod;
        mod7 <= mod7_of(days);
      end
      if (cmd.year_step && !stat.year_done) begin
        days <= days - 16'(ylen);
        year <= year + 8'd1;
        y4   <= y4 + 2'd1;
        y100 <= (y100 == 7'd99)  ? 7'd0 : y100 + 7'd1;
        y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
      end
      if (cmd.month_step && !stat.month_done) begin
        month_start <= month_end;
        mon         <= mon + 4'd1;
      end
      // peel hours first, then minutes; the remainder is seconds
      if (cmd.hms_run && !stat.hms_done) begin
        if (rem >= SECS_PER_HOUR) begin
          rem  <= rem - SECS_PER_HOUR;
          hour <= hour + 5'd1;
        end else begin
          rem    <= rem - SECS_PER_MIN;
          minute <= minute + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (is_zero) begin
        valid_res        <= 1'b0;
        years_since_1900 <= '0;
        month_index      <= '0;
        day_of_month     <= '0;
        day_of_year      <= '0;
        weekday          <= '0;
        hour_of_day      <= '0;
        minute_of_hour   <= '0;
        second_of_minute <= '0;
      end else begin
        valid_res        <= 1'b1;
        years_since_1900 <= year;
        month_index      <= mon;
        day_of_month     <= mday[4:0];
        day_of_year      <= days[8:0];
        weekday          <= wd;
        hour_of_day      <= hour;
        minute_of_hour   <= minute;
        second_of_minute <= rem[5:0];
      end
    end
  end

endmodule

// ----- rtl/eutc_ctrl.sv -----
// ----------------------------------------------------------------------------
// eutc_ctrl
// Controller: sequences day count, time of day, year, month and output
// phases and runs the request handshakes on both channels.
// ----------------------------------------------------------------------------
module eutc_ctrl
  import eutc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output eutc_cmd_t  cmd,
  input  eutc_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAYS,
    S_TOD,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.day_calc   = (state == S_DAYS);
    cmd.tod_calc   = (state == S_TOD);
    cmd.year_step  = (state == S_YEAR);
    cmd.month_step = (state == S_MONTH);
    cmd.hms_run    = (state == S_YEAR) || (state == S_MONTH) || (state == S_FINISH);
    cmd.out_load   = (state == S_FINISH) && stat.hms_done && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken; a new one may replace it in the same cycle
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DAYS;
        end
        S_DAYS: begin
          state <= S_TOD;
        end
        S_TOD: begin
          state <= S_YEAR;
        end
        S_YEAR: begin
          if (stat.year_done) state <= S_MONTH;
        end
        S_MONTH: begin
          if (stat.month_done) state <= S_FINISH;
        end
        S_FINISH: begin
          if (cmd.out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/epoch_seconds_to_utc_calendar.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar
// Converts unsigned seconds since 1970-01-01 UTC into UTC calendar fields.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with epoch_seconds. A request is taken
// when in_valid is high and in_stall is low. in_stall is high while a
// conversion is in progress; one request is converted at a time.
// Output channel: out_valid / out_stall with the calendar fields. A result is
// taken when out_valid is high and out_stall is low.
// Steps: the day count (reciprocal multiply), then time of day and weekday,
// then one year step per year from 1970, then one month step per month (up to
// 11), then the output load. Hour/minute extraction (up to 82 subtract steps)
// runs beside the year and month loops, and the output load waits for it to
// finish. The result sits in an output register, so a new request is accepted
// the cycle after the result is loaded. If the receiver stalls, the result
// holds and a finished conversion waits until the output register frees up.
// An input of zero returns valid_res = 0 with every other field zero.
// Reset (rst, synchronous) returns the controller to idle and drops out_valid.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar
  import eutc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [7:0]  years_since_1900,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [8:0]  day_of_year,
  output logic [2:0]  weekday,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);

  eutc_cmd_t  cmd;
  eutc_stat_t stat;

  eutc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  eutc_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .stat             (stat),
    .epoch_seconds    (epoch_seconds),
    .valid_res        (valid_res),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .day_of_year      (day_of_year),
    .weekday          (weekday),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the epoch seconds to UTC calendar converter.
// A short table of boundary dates is played first, then random instants
// biased toward midnight, the epoch and the top of the 32-bit range. Every
// result is compared field by field against a calendar computed here, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [8:0] day_of_year;
    logic [2:0] weekday;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } calendar_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        typed;
    calendar_t   want;
  } stim_row_t;

  localparam int unsigned SECS_IN_DAY  = 86400;
  localparam int unsigned SECS_IN_HOUR = 3600;
  localparam int unsigned SECS_IN_MIN  = 60;
  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int unsigned CENTURY_BASE = 1900;
  localparam int unsigned LAST_DAY_IDX = 49709;   // last full day below 2^32 s
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned WEEKDAY_SHIFT [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  localparam int          HOLD_CYCLES  = 400;
  localparam int          SEGMENTS     = 8;
  localparam int          SEGMENT_LEN  = 228;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] epoch_seconds = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        valid_res;
  logic [7:0]  years_since_1900;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;
  logic [8:0]  day_of_year;
  logic [2:0]  weekday;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;

  calendar_t calendar_due [$];
  int        mismatch_count = 0;
  bit        no_idle = 1'b0;
  bit        hold_results = 1'b0;
  int        rush_left = 0;

  stim_row_t directed_rows [24] = '{
    '{32'd0,          1'b1, '0},
    '{32'd1,          1'b1, '{1'b1, 8'd70, 4'd0, 5'd1, 9'd0, 3'd4, 5'd0, 6'd0, 6'd1}},
    '{32'd86399,      1'b1, '{1'b1, 8'd70, 4'd0, 5'd1, 9'd0, 3'd4, 5'd23, 6'd59, 6'd59}},
    '{32'd86400,      1'b1, '{1'b1, 8'd70, 4'd0, 5'd2, 9'd1, 3'd5, 5'd0, 6'd0, 6'd0}},
    '{32'hFFFFFFFF,   1'b1, '{1'b1, 8'd206, 4'd1, 5'd7, 9'd37, 3'd0, 5'd6, 6'd28, 6'd15}},
    '{32'd59,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd3600,       1'b0, '0},
    '{32'd31535999,   1'b0, '0},
    '{32'd31536000,   1'b0, '0},
    '{32'd68169599,   1'b0, '0},
    '{32'd68169600,   1'b0, '0},
    '{32'd946684799,  1'b0, '0},
    '{32'd946684800,  1'b0, '0},
    '{32'd951782400,  1'b0, '0},
    '{32'd978307199,  1'b0, '0},
    '{32'd1583020800, 1'b0, '0},
    '{32'd4107542399, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0},
    '{32'h7FFFFFFF,   1'b0, '0},
    '{32'h80000000,   1'b0, '0},
    '{32'h55555555,   1'b0, '0},
    '{32'hAAAAAAAA,   1'b0, '0},
    '{32'hFFFFFFFE,   1'b0, '0}
  };

  epoch_seconds_to_utc_calendar u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .epoch_seconds    (epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .valid_res        (valid_res),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .day_of_year      (day_of_year),
    .weekday          (weekday),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit gregorian_leap(input int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  function automatic calendar_t utc_fields(input logic [31:0] secs);
    calendar_t   cal;
    int unsigned days, tod, year, ylen, mon, mlen, month_start, mday, wy;
    bit          leap;
    cal = '0;
    if (secs != 32'd0) begin
      days = secs / SECS_IN_DAY;
      tod  = secs % SECS_IN_DAY;
      year = EPOCH_YEAR;
      ylen = gregorian_leap(year) ? 366 : 365;
      while (days >= ylen) begin
        days -= ylen;
        year++;
        ylen = gregorian_leap(year) ? 366 : 365;
      end
      // December takes whatever is left
      leap = gregorian_leap(year);
      mon = 0;
      month_start = 0;
      while (mon < 11) begin
        mlen = MONTH_DAYS[mon] + ((leap && mon == 1) ? 1 : 0);
        if (month_start + mlen > days) break;
        month_start += mlen;
        mon++;
      end
      mday = days - month_start + 1;
      // January and February count as part of the previous year here
      wy = year - ((mon < 2) ? 1 : 0);
      cal.valid_res        = 1'b1;
      cal.years_since_1900 = 8'(year - CENTURY_BASE);
      cal.month_index      = 4'(mon);
      cal.day_of_month     = 5'(mday);
      cal.day_of_year      = 9'(days);
      cal.weekday          = 3'((wy + wy / 4 - wy / 100 + wy / 400 + WEEKDAY_SHIFT[mon] + mday) % 7);
      cal.hour_of_day      = 5'(tod / SECS_IN_HOUR);
      cal.minute_of_hour   = 6'((tod % SECS_IN_HOUR) / SECS_IN_MIN);
      cal.second_of_minute = 6'(tod % SECS_IN_MIN);
    end
    return cal;
  endfunction

  function automatic int pick_wait();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic offer_request(input logic [31:0] secs, input logic typed, input calendar_t want);
    int gap;
    gap = (rush_left > 0) ? 0 : pick_wait();
    if (rush_left > 0) rush_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calendar_due.push_back(typed ? want : utc_fields(secs));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (calendar_due.size() != 0) @(posedge clk);
  endtask

  // result side: stall for a random gap before each result, or for HOLD_CYCLES once when a segment asks
  initial begin
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_results) begin
        n = HOLD_CYCLES;
        hold_results = 1'b0;
      end else begin
        n = pick_wait();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : watch_results
    calendar_t want;
    if (!rst && out_valid && !out_stall) begin
      if (calendar_due.size() == 0) begin
        $error("result with no pending request");
        mismatch_count++;
      end else begin
        want = calendar_due.pop_front();
        check_field("valid_res", want.valid_res, valid_res);
        check_field("years_since_1900", want.years_since_1900, years_since_1900);
        check_field("month_index", want.month_index, month_index);
        check_field("day_of_month", want.day_of_month, day_of_month);
        check_field("day_of_year", want.day_of_year, day_of_year);
        check_field("weekday", want.weekday, weekday);
        check_field("hour_of_day", want.hour_of_day, hour_of_day);
        check_field("minute_of_hour", want.minute_of_hour, minute_of_hour);
        check_field("second_of_minute", want.second_of_minute, second_of_minute);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[epoch_seconds_to_utc_calendar] ERROR");
    $finish;
  end

  initial begin
    int unsigned d;
    logic [31:0] secs;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(directed_rows); i++)
      offer_request(directed_rows[i].secs, directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      no_idle = (seg == 3 || seg == 6);
      if (seg == 2) begin
        // back up the converter behind a long result stall
        hold_results = 1'b1;
        rush_left    = 20;
      end
      if (seg == 5) wait_drained();
      for (int k = 0; k < SEGMENT_LEN; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: secs = $urandom;
          5, 6, 7: begin
            d = $urandom_range(0, LAST_DAY_IDX);
            case ($urandom_range(0, 2))
              0:       secs = d * SECS_IN_DAY;
              1:       secs = d * SECS_IN_DAY + SECS_IN_DAY - 1;
              default: secs = d * SECS_IN_DAY + $urandom_range(0, SECS_IN_DAY - 1);
            endcase
          end
          8:       secs = $urandom_range(0, 1500 * SECS_IN_DAY);
          default: secs = 32'hFFFFFFFF - $urandom_range(0, 200000);
        endcase
        offer_request(secs, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (calendar_due.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (mismatch_count == 0)
      $display("[epoch_seconds_to_utc_calendar] OK");
    else
      $display("[epoch_seconds_to_utc_calendar] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/eutc_pkg.sv
rtl/eutc_dp.sv
rtl/eutc_ctrl.sv
rtl/epoch_seconds_to_utc_calendar.sv
tb/sv/tb.sv
